// File: rtl/csts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csts_pkg
// Shared types and constants of the C-style token scanner: token kinds,
// the keyword table and the descriptor word that leaves the scanner.
// ---------------------------------------------------------------------------
package csts_pkg;

  localparam int OUT_POS_W = 16;
  localparam int OUT_LEN_W = 8;

  localparam int NUM_KW  = 15;
  // characters that the keyword filter looks at; no keyword is longer
  localparam int KW_POS  = 8;
  localparam int KW_W    = 8 * KW_POS;

  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CH_US    = 8'h5f;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7a;

  // keyword text, left aligned, first character in the top byte
  localparam logic [KW_W-1:0] KW_TEXT [NUM_KW] = '{
    {"if",       48'h0},
    {"else",     32'h0},
    {"while",    24'h0},
    {"for",      40'h0},
    {"int",      40'h0},
    {"float",    24'h0},
    {"char",     32'h0},
    {"void",     32'h0},
    {"return",   16'h0},
    {"break",    24'h0},
    {"continue"},
    {"do",       48'h0},
    {"switch",   16'h0},
    {"case",     32'h0},
    {"default",  8'h0}
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd4, 4'd5, 4'd3, 4'd3, 4'd5, 4'd4, 4'd4,
    4'd6, 4'd5, 4'd8, 4'd2, 4'd6, 4'd4, 4'd7
  };

  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_REL     = 3'd3,
    KIND_END     = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [OUT_POS_W-1:0] line;
    logic [OUT_POS_W-1:0] column;
    logic [OUT_LEN_W-1:0] length;
    logic                 last;
  } token_t;

  // up to two descriptors produced by one word
  typedef struct packed {
    logic [1:0]       count;
    token_t [1:0]     tok;
  } emit_t;

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [KW_W-1:0] w;
    w = KW_TEXT[k];
    return w[KW_W-1 - 8*int'(pos) -: 8];
  endfunction

endpackage

// File: rtl/csts_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csts_in_if
// Text byte channel: valid/ready handshake with one byte or end marker.
// ---------------------------------------------------------------------------
interface csts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

// File: rtl/csts_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csts_out_if
// Token descriptor channel: valid/ready handshake with one descriptor.
// ---------------------------------------------------------------------------
interface csts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [7:0]  token_length;
  logic        last;

  modport source (output valid, token_kind, start_line, start_column, token_length, last,
                  input ready);
  modport sink   (input valid, token_kind, start_line, start_column, token_length, last,
                  output ready);
endinterface

// File: rtl/csts_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csts_scan
// Scanner state and per-byte logic: classifies the byte, moves the token
// state machine, tracks line/column and reports up to two descriptors.
// ---------------------------------------------------------------------------
module csts_scan #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_BITS   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  logic                eoi_i,
  output csts_pkg::emit_t     emit_o
);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_FRAC  = 3'd3,
    MODE_OP    = 3'd4
  } mode_e;

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;

  mode_e                      mode_q, mode_d;
  logic [POSITION_BITS-1:0]   line_q, line_d, col_q, col_d;
  logic [POSITION_BITS-1:0]   tline_q, tline_d, tcol_q, tcol_d;
  logic [POSITION_BITS-1:0]   adv_line, adv_col;
  logic [LENGTH_BITS-1:0]     len_q, len_d, len_inc;
  logic [csts_pkg::NUM_KW-1:0] cand_q, cand_d, cand_filt, cand_start;

  logic eoi, is_letter, is_digit, is_space, is_op, is_us, is_dot;
  logic kw_hit, cont, op_eq, fresh, closed, femit;
  csts_pkg::kind_e  close_kind;
  csts_pkg::token_t ctok, ftok;
  csts_pkg::emit_t  emit;

  always_comb begin
    eoi       = eoi_i || (char_i == csts_pkg::CH_NUL);
    is_letter = (char_i >= csts_pkg::CH_UC_A && char_i <= csts_pkg::CH_UC_Z) ||
                (char_i >= csts_pkg::CH_LC_A && char_i <= csts_pkg::CH_LC_Z);
    is_digit  = char_i >= csts_pkg::CH_0 && char_i <= csts_pkg::CH_9;
    is_space  = char_i == csts_pkg::CH_SPACE ||
                (char_i >= csts_pkg::CH_TAB && char_i <= csts_pkg::CH_CR);
    is_op     = char_i == csts_pkg::CH_EQ || char_i == csts_pkg::CH_BANG ||
                char_i == csts_pkg::CH_LT || char_i == csts_pkg::CH_GT;
    is_us     = char_i == csts_pkg::CH_US;
    is_dot    = char_i == csts_pkg::CH_DOT;

    // position after consuming this byte
    if (char_i == csts_pkg::CH_LF) begin
      adv_line = (line_q == POS_MAX) ? line_q : line_q + POS_ONE;
      adv_col  = POS_ONE;
    end else begin
      adv_line = line_q;
      adv_col  = (col_q == POS_MAX) ? col_q : col_q + POS_ONE;
    end

    len_inc = (len_q == LEN_MAX) ? len_q : len_q + LEN_ONE;

    // keyword candidates: filter at the current position, and first-char match
    kw_hit = 1'b0;
    for (int k = 0; k < csts_pkg::NUM_KW; k++) begin
      cand_filt[k]  = cand_q[k] && (len_q < LENGTH_BITS'(csts_pkg::KW_POS)) &&
                      (csts_pkg::kw_char(k, len_q[2:0]) == char_i);
      cand_start[k] = csts_pkg::kw_char(k, 3'd0) == char_i;
      if (cand_q[k] && len_q == LENGTH_BITS'(csts_pkg::KW_LEN[k])) begin
        kw_hit = 1'b1;
      end
    end

    case (mode_q)
      MODE_IDENT: close_kind = kw_hit ? csts_pkg::KIND_KEYWORD : csts_pkg::KIND_IDENT;
      MODE_INT,
      MODE_FRAC:  close_kind = csts_pkg::KIND_NUMBER;
      default:    close_kind = csts_pkg::KIND_REL;
    endcase

    cont = !eoi && (((mode_q == MODE_IDENT) && (is_letter || is_digit || is_us)) ||
                    ((mode_q == MODE_INT) && (is_digit || is_dot)) ||
                    ((mode_q == MODE_FRAC) && is_digit));
    op_eq = !eoi && (mode_q == MODE_OP) && (char_i == csts_pkg::CH_EQ);

    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    len_d   = len_q;
    cand_d  = cand_q;
    fresh   = 1'b1;
    closed  = 1'b0;
    femit   = 1'b0;

    ctok.kind   = close_kind;
    ctok.line   = csts_pkg::OUT_POS_W'(tline_q);
    ctok.column = csts_pkg::OUT_POS_W'(tcol_q);
    ctok.length = csts_pkg::OUT_LEN_W'(len_q);
    ctok.last   = 1'b1;

    ftok.kind   = csts_pkg::KIND_UNKNOWN;
    ftok.line   = csts_pkg::OUT_POS_W'(line_q);
    ftok.column = csts_pkg::OUT_POS_W'(col_q);
    ftok.length = csts_pkg::OUT_LEN_W'(LEN_ONE);
    ftok.last   = 1'b1;

    if (mode_q != MODE_IDLE) begin
      if (cont) begin
        fresh  = 1'b0;
        len_d  = len_inc;
        line_d = adv_line;
        col_d  = adv_col;
        if (mode_q == MODE_IDENT) begin
          cand_d = cand_filt;
        end
        if (mode_q == MODE_INT && is_dot) begin
          mode_d = MODE_FRAC;
        end
      end else if (op_eq) begin
        // two-character relational operator
        fresh       = 1'b0;
        closed      = 1'b1;
        ctok.kind   = csts_pkg::KIND_REL;
        ctok.length = csts_pkg::OUT_LEN_W'(len_inc);
        line_d      = adv_line;
        col_d       = adv_col;
        mode_d      = MODE_IDLE;
        len_d       = '0;
      end else begin
        closed = 1'b1;
        mode_d = MODE_IDLE;
        len_d  = '0;
      end
    end

    if (fresh) begin
      if (eoi) begin
        femit       = 1'b1;
        ftok.kind   = csts_pkg::KIND_END;
        ftok.length = '0;
        mode_d      = MODE_IDLE;
        line_d      = POS_ONE;
        col_d       = POS_ONE;
        tline_d     = POS_ONE;
        tcol_d      = POS_ONE;
        len_d       = '0;
        cand_d      = '1;
      end else if (is_space) begin
        line_d = adv_line;
        col_d  = adv_col;
      end else if (is_letter || is_us || is_digit || is_op) begin
        tline_d = line_q;
        tcol_d  = col_q;
        len_d   = LEN_ONE;
        line_d  = adv_line;
        col_d   = adv_col;
        if (is_digit) begin
          mode_d = MODE_INT;
        end else if (is_op) begin
          mode_d = MODE_OP;
        end else begin
          mode_d = MODE_IDENT;
          cand_d = cand_start;
        end
      end else begin
        femit  = 1'b1;
        line_d = adv_line;
        col_d  = adv_col;
      end
    end

    emit.count = 2'd0;
    emit.tok   = {ctok, ctok};
    if (closed && femit) begin
      ctok.last   = 1'b0;
      emit.tok[0] = ctok;
      emit.tok[1] = ftok;
      emit.count  = 2'd2;
    end else if (closed) begin
      emit.tok[0] = ctok;
      emit.count  = 2'd1;
    end else if (femit) begin
      emit.tok[0] = ftok;
      emit.count  = 2'd1;
    end
    if (!step_i) begin
      emit.count = 2'd0;
    end
  end

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= POS_ONE;
      col_q   <= POS_ONE;
      tline_q <= POS_ONE;
      tcol_q  <= POS_ONE;
      len_q   <= '0;
      cand_q  <= '1;
    end else if (step_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      len_q   <= len_d;
      cand_q  <= cand_d;
    end
  end

endmodule

// File: rtl/c_style_token_scanner.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c_style_token_scanner
// Streaming lexer for C-style text: one byte per word in, token descriptors
// (kind, start line, start column, length) out.
// ---------------------------------------------------------------------------
//
//  channel | dir | word
//  --------+-----+---------------------------------------------------------
//  in_i    | in  | char_code, end_of_input
//  out_o   | out | token_kind, start_line, start_column, token_length, last
//
// One byte per cycle while the result queue has room. A byte is held in the
// input register, is scanned and its 0..2 descriptors land in a 4-entry
// result queue; the queue drains one descriptor per cycle while the receiver
// is ready, so bytes that close one token and start an emitting one add two
// descriptors. Input stalls only when the queue cannot take two more. Reset
// leaves position 1:1 and no open token; no clearing pass is needed.
// ---------------------------------------------------------------------------
module c_style_token_scanner #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_BITS   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  csts_in_if.sink     in_i,
  csts_out_if.source  out_o
);

  localparam int PTR_W = $clog2(csts_pkg::FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic                    in_vld_q;
  logic [7:0]              char_q;
  logic                    eoi_q;
  logic                    room, step, pop;
  csts_pkg::emit_t         emit;
  csts_pkg::token_t        fifo_q [csts_pkg::FIFO_DEPTH];
  csts_pkg::token_t        head;
  logic [PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  assign room       = cnt_q <= CNT_W'(csts_pkg::FIFO_DEPTH - 2);
  assign step       = in_vld_q && room;
  assign in_i.ready = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_q <= in_i.char_code;
      eoi_q  <= in_i.end_of_input;
    end
  end

  csts_scan #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (char_q),
    .eoi_i  (eoi_q),
    .emit_o (emit)
  );

  // result queue
  assign head  = fifo_q[rd_ptr_q];
  assign pop   = out_o.valid && out_o.ready;
  assign cnt_d = cnt_q + CNT_W'(emit.count) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(emit.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.count != 2'd0) begin
      fifo_q[wr_ptr_q] <= emit.tok[0];
    end
    if (emit.count == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= emit.tok[1];
    end
  end

  assign out_o.valid        = cnt_q != '0;
  assign out_o.token_kind   = head.kind;
  assign out_o.start_line   = head.line;
  assign out_o.start_column = head.column;
  assign out_o.token_length = head.length;
  assign out_o.last         = head.last;

endmodule

// File: tb/sv/csts_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csts_scoreboard_pkg
// Token scoreboard for the C-style scanner: predicts the descriptors of each
// accepted byte word and checks the descriptors leaving the block in order.
// ---------------------------------------------------------------------------
package csts_scoreboard_pkg;
  import csts_pkg::*;

  localparam logic [OUT_POS_W-1:0] POS_TOP = {OUT_POS_W{1'b1}};
  localparam logic [OUT_LEN_W-1:0] LEN_TOP = {OUT_LEN_W{1'b1}};
  localparam int                   SHOWN_MISMATCHES = 10;

  function automatic string keyword_text(input int k);
    case (k)
      0:  return "if";
      1:  return "else";
      2:  return "while";
      3:  return "for";
      4:  return "int";
      5:  return "float";
      6:  return "char";
      7:  return "void";
      8:  return "return";
      9:  return "break";
      10: return "continue";
      11: return "do";
      12: return "switch";
      13: return "case";
      14: return "default";
      default: return "";
    endcase
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_rel(input logic [7:0] c);
    return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT;
  endfunction

  class token_scoreboard;
    typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_IDENT, SCAN_INT, SCAN_FRAC, SCAN_OP
    } scan_e;

    scan_e                mode;
    logic [OUT_POS_W-1:0] line_no;
    logic [OUT_POS_W-1:0] col_no;
    logic [OUT_POS_W-1:0] tok_line;
    logic [OUT_POS_W-1:0] tok_col;
    logic [OUT_LEN_W-1:0] tok_len;
    logic [NUM_KW-1:0]    kw_alive;

    token_t      expected_tokens[$];
    int unsigned n_fail;
    int unsigned n_checked;
    int unsigned kind_hits[6];

    function new();
      clear_scan();
    endfunction

    function void clear_scan();
      mode     = SCAN_IDLE;
      line_no  = OUT_POS_W'(1);
      col_no   = OUT_POS_W'(1);
      tok_line = OUT_POS_W'(1);
      tok_col  = OUT_POS_W'(1);
      tok_len  = '0;
      kw_alive = '1;
    endfunction

    function void step_position(input logic [7:0] c);
      if (c == CH_LF) begin
        if (line_no != POS_TOP) line_no++;
        col_no = OUT_POS_W'(1);
      end else if (col_no != POS_TOP) begin
        col_no++;
      end
    endfunction

    function logic [OUT_LEN_W-1:0] len_plus(input logic [OUT_LEN_W-1:0] v);
      return (v == LEN_TOP) ? v : v + 1'b1;
    endfunction

    // drop keywords whose next character does not match
    function void narrow_keywords(input logic [7:0] c);
      for (int k = 0; k < NUM_KW; k++) begin
        string w;
        w = keyword_text(k);
        if (!(tok_len < KW_POS && tok_len < w.len() && w[tok_len] == c)) kw_alive[k] = 1'b0;
      end
    endfunction

    function bit keyword_complete();
      if (tok_len > KW_POS) return 1'b0;
      for (int k = 0; k < NUM_KW; k++) begin
        string w;
        w = keyword_text(k);
        if (kw_alive[k] && w.len() == tok_len) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void push_token(input kind_e kind, input logic [OUT_POS_W-1:0] ln,
                             input logic [OUT_POS_W-1:0] col, input logic [OUT_LEN_W-1:0] len);
      token_t t;
      t.kind   = kind;
      t.line   = ln;
      t.column = col;
      t.length = len;
      t.last   = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    // one accepted input word
    function void note_word(input logic [7:0] c, input logic eoi_in);
      int    n_before;
      bit    eoi;
      bit    grows;
      bit    closed;
      kind_e kind;
      n_before = expected_tokens.size();
      eoi      = eoi_in || c == CH_NUL;
      closed   = 1'b0;
      if (mode != SCAN_IDLE) begin
        grows = 1'b0;
        if (!eoi) begin
          if (mode == SCAN_IDENT && (is_alpha(c) || is_num(c) || c == CH_US)) begin
            narrow_keywords(c);
            grows = 1'b1;
          end else if (mode == SCAN_INT && (is_num(c) || c == CH_DOT)) begin
            if (c == CH_DOT) mode = SCAN_FRAC;
            grows = 1'b1;
          end else if (mode == SCAN_FRAC && is_num(c)) begin
            grows = 1'b1;
          end else if (mode == SCAN_OP && c == CH_EQ) begin
            // two-character relational, nothing left to rescan
            push_token(KIND_REL, tok_line, tok_col, len_plus(tok_len));
            step_position(c);
            mode    = SCAN_IDLE;
            tok_len = '0;
            closed  = 1'b1;
          end
        end
        if (grows) begin
          tok_len = len_plus(tok_len);
          step_position(c);
          closed = 1'b1;
        end else if (!closed) begin
          kind = KIND_REL;
          if (mode == SCAN_IDENT) kind = keyword_complete() ? KIND_KEYWORD : KIND_IDENT;
          else if (mode == SCAN_INT || mode == SCAN_FRAC) kind = KIND_NUMBER;
          push_token(kind, tok_line, tok_col, tok_len);
          mode    = SCAN_IDLE;
          tok_len = '0;
        end
      end

      if (!closed) begin
        if (eoi) begin
          push_token(KIND_END, line_no, col_no, '0);
          clear_scan();
        end else if (is_blank(c)) begin
          step_position(c);
        end else if (is_alpha(c) || c == CH_US || is_num(c) || is_rel(c)) begin
          tok_line = line_no;
          tok_col  = col_no;
          tok_len  = '0;
          if (is_num(c)) begin
            mode = SCAN_INT;
          end else if (is_rel(c)) begin
            mode = SCAN_OP;
          end else begin
            mode     = SCAN_IDENT;
            kw_alive = '1;
            narrow_keywords(c);
          end
          tok_len = len_plus('0);
          step_position(c);
        end else begin
          push_token(KIND_UNKNOWN, line_no, col_no, len_plus('0));
          step_position(c);
        end
      end

      if (expected_tokens.size() > n_before)
        expected_tokens[expected_tokens.size()-1].last = 1'b1;
    endfunction

    function string show(input token_t t);
      return $sformatf("kind %0d line %0d col %0d len %0d last %0b",
                       t.kind, t.line, t.column, t.length, t.last);
    endfunction

    function void flag(input string msg);
      n_fail++;
      if (n_fail <= SHOWN_MISMATCHES) $display("ERROR: %s", msg);
    endfunction

    // one accepted descriptor
    function void check(input token_t got);
      token_t want;
      n_checked++;
      if (int'(got.kind) < 6) kind_hits[int'(got.kind)]++;
      if (expected_tokens.size() == 0) begin
        flag($sformatf("descriptor with nothing expected: %s", show(got)));
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.line !== want.line || got.column !== want.column ||
          got.length !== want.length || got.last !== want.last)
        flag($sformatf("expected %s, got %s", show(want), show(got)));
    endfunction

    function void close_out();
      if (expected_tokens.size() != 0) begin
        flag($sformatf("%0d descriptors never arrived, first: %s",
                       expected_tokens.size(), show(expected_tokens[0])));
        n_fail += expected_tokens.size() - 1;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/c_style_token_scanner_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c_style_token_scanner_tb
// Drives byte words into the scanner with random gaps and output stalls and
// checks every token descriptor against a predicted stream.
// ---------------------------------------------------------------------------
module c_style_token_scanner_tb;
  import csts_pkg::*;
  import csts_scoreboard_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYC   = 8;
  localparam int CYCLE_LIMIT = 250_000;
  localparam int RANDOM_BUSY = 700;
  localparam int RANDOM_CALM = 200;
  localparam int TAIL_CYC    = 20;

  localparam logic [7:0] REL_CHARS [4] = '{CH_EQ, CH_BANG, CH_LT, CH_GT};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  csts_in_if  in_if ();
  csts_out_if out_if ();

  c_style_token_scanner i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  token_scoreboard sb;
  bit              gaps_on;
  bit              stall_on;
  int unsigned     n_sent;
  int unsigned     n_cycles;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: ready drops in random bursts
  initial begin
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) stall--;
      else if (stall_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 12);
      out_if.ready <= (stall == 0);
    end
  end

  always @(posedge clk_i) begin
    token_t got;
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_word(in_if.char_code, in_if.end_of_input);
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind   = kind_e'(out_if.token_kind);
      got.line   = out_if.start_line;
      got.column = out_if.start_column;
      got.length = out_if.token_length;
      got.last   = out_if.last;
      sb.check(got);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [7:0] c, input logic eoi);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.char_code    <= c;
    in_if.end_of_input <= eoi;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // hold the sender until every predicted descriptor has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_word_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'(CH_UC_A + r);
    if (r < 52) return 8'(CH_LC_A + r - 26);
    if (r == 52) return CH_US;
    return 8'(CH_0 + r - 53);
  endfunction

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_word(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
  endtask

  task automatic send_token();
    int         pick;
    int         n;
    string      w;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // keyword, sometimes cut short or extended
      w = keyword_text($urandom_range(0, NUM_KW - 1));
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w.len()) : w.len();
      for (int i = 0; i < n; i++) send_word(w[i], 1'b0);
      if ($urandom_range(0, 4) == 0) send_word(pick_word_char(1'b0), 1'b0);
    end else if (pick < 35) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) send_word(pick_word_char(i == 0), 1'b0);
    end else if (pick < 50) begin
      send_digits($urandom_range(1, 4));
      if ($urandom_range(0, 1) == 0) begin
        send_word(CH_DOT, 1'b0);
        send_digits($urandom_range(0, 3));
        if ($urandom_range(0, 5) == 0) send_word(CH_DOT, 1'b0);
      end
    end else if (pick < 62) begin
      send_word(REL_CHARS[2'($urandom_range(0, 3))], 1'b0);
      if ($urandom_range(0, 1) == 0) send_word(CH_EQ, 1'b0);
    end else if (pick < 80) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(0, 6));
        send_word((c >= 5) ? CH_SPACE : CH_TAB + c, 1'b0);
      end
    end else if (pick < 88) begin
      do c = 8'($urandom_range(1, 255));
      while (is_alpha(c) || is_num(c) || c == CH_US || is_rel(c) || is_blank(c));
      send_word(c, 1'b0);
    end else if (pick < 96) begin
      send_word(8'($urandom_range(1, 255)), 1'b0);
    end else if (pick < 98) begin
      send_word(CH_NUL, 1'b0);
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int unsigned mark;
    sb                 = new();
    gaps_on            = 1'b1;
    stall_on           = 1'b1;
    in_if.valid        = 1'b0;
    in_if.char_code    = '0;
    in_if.end_of_input = 1'b0;
    repeat (RESET_CYC) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: keyword, two-char relational, fraction, second dot, op then
    // letter, high byte, tab, newline, zero byte as end, op pending at end
    send_text("if<=9.5.!x");
    send_word(8'hff, 1'b0);
    send_text("\t>a\nwhile");
    send_word(CH_NUL, 1'b0);
    send_word(CH_EQ, 1'b0);
    send_word(8'h71, 1'b1);
    drain();

    // length saturation: identifier far past every keyword
    gaps_on = 1'b0;
    send_word(CH_US, 1'b0);
    repeat (299) send_word(pick_word_char(1'b0), 1'b0);
    send_word(CH_SPACE, 1'b0);
    send_text("continue continues ");
    send_word(8'h00, 1'b1);
    drain();

    gaps_on = 1'b1;
    mark    = n_sent;
    while (n_sent - mark < RANDOM_BUSY) begin
      send_token();
      if ($urandom_range(0, 199) == 0) drain();
    end
    drain();

    // closing stretch with no idling on either side
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    mark     = n_sent;
    while (n_sent - mark < RANDOM_CALM) send_token();
    send_word(8'h00, 1'b1);
    in_if.valid <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
    sb.close_out();

    $display("%0d byte words sent, %0d descriptors checked in %0d cycles",
             n_sent, sb.n_checked, n_cycles);
    $display("mix: ident %0d keyword %0d number %0d rel %0d end %0d unknown %0d; errors %0d",
             sb.kind_hits[0], sb.kind_hits[1], sb.kind_hits[2], sb.kind_hits[3],
             sb.kind_hits[4], sb.kind_hits[5], sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
